// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define ASSERT_IMPL(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication: cons must hold in the cycle after ante.
`define ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/busdec_pkg.sv
// ----------------------------------------------------------------------------
// busdec_pkg
// Shared types and constants of the bus address decoder.
// ----------------------------------------------------------------------------
package busdec_pkg;

  localparam int NUM_WINDOWS_DEF     = 4;
  localparam int IO_WINDOW_BYTES_DEF = 64;
  localparam int IRAM_BYTES_DEF      = 256;

  // Register slots for external windows and bits in each handler mask.
  localparam int WIN_SLOTS    = 4;
  localparam int IO_MASK_BITS = 64;
  localparam int WIN_W        = 33;

  localparam int ADDR_W    = 16;
  localparam int DATA_W    = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 64;

  localparam logic [DATA_W-1:0] UNMAPPED_READ = 8'hFF;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IO_BASE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RAM_BASE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RD_MASK  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WR_MASK  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN0     = 3'd4;

  localparam logic [ADDR_W-1:0] IO_BASE_RST = 16'h1000;

  localparam int FIFO_DEPTH = 2;

  typedef enum logic [1:0] {
    TGT_IO   = 2'd0,
    TGT_RAM  = 2'd1,
    TGT_EXT  = 2'd2,
    TGT_NONE = 2'd3
  } target_t;

  // One classified access, handed from the front end to the back end.
  typedef struct packed {
    target_t             target;
    logic [1:0]          win_idx;
    logic [ADDR_W-1:0]   offset;
    logic                wr;
    logic [DATA_W-1:0]   wdata;
    logic                fwd;
    logic                drop;
  } acc_t;

endpackage

// File: rtl/bus_address_decoder_with_iram.sv
// ----------------------------------------------------------------------------
// bus_address_decoder_with_iram
// Byte bus address decoder with register window, internal RAM and windows.
// ----------------------------------------------------------------------------
// Each accepted word is one byte access (cmd 0 read, 1 write) at a 16-bit
// address and yields exactly one result word, in order. Decode priority:
// the register window at io_base (only where io_read_mask / io_write_mask
// has a handler bit for that offset and direction), then the internal RAM
// at ram_base, then external windows 0..3 in index order, else unmapped
// (reads return 0xFF). Regions end at 0xFFFF and never wrap. Register and
// external accesses are routed out as target, window index and offset; RAM
// reads return the stored byte. Throughput is one access per clock while
// the output is not stalled and no sweep runs: the front end classifies
// with all region compares in parallel, a two-entry queue decouples it
// from the back end, and the back end does the single RAM access and holds
// the result word in an output register; an access is registered in the
// queue, then in the output register. After reset the RAM is cleared by a
// sweep over all IRAM_BYTES bytes (256 by default), during which in_ready
// stays low; configuration writes are taken at all times (cfg_ready is
// tied high) and must be made while no access is in flight.
// ----------------------------------------------------------------------------
module bus_address_decoder_with_iram #(
  parameter int NUM_WINDOWS     = busdec_pkg::NUM_WINDOWS_DEF,
  parameter int IO_WINDOW_BYTES = busdec_pkg::IO_WINDOW_BYTES_DEF,
  parameter int IRAM_BYTES      = busdec_pkg::IRAM_BYTES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [busdec_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [busdec_pkg::CFG_DAT_W-1:0]   cfg_data,
  // access channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_cmd,
  input  logic [busdec_pkg::ADDR_W-1:0]      in_address,
  input  logic [busdec_pkg::DATA_W-1:0]      in_write_data,
  // result channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [1:0]                         out_target,
  output logic [1:0]                         out_window_index,
  output logic [busdec_pkg::ADDR_W-1:0]      out_offset,
  output logic [busdec_pkg::DATA_W-1:0]      out_read_data,
  output logic                               out_forward_write,
  output logic                               out_write_dropped
);

  busdec_pkg::acc_t front_acc;
  busdec_pkg::acc_t q_data;
  logic             q_full;
  logic             q_valid;
  logic             q_pop;
  logic             clearing;
  logic             push;

  // Always take configuration words.
  assign cfg_ready = 1'b1;

  // Hold off accesses while the queue is full or the RAM sweep runs.
  assign in_ready = !q_full && !clearing;
  assign push     = in_valid && in_ready;

  busdec_front #(
    .NUM_WINDOWS     (NUM_WINDOWS),
    .IO_WINDOW_BYTES (IO_WINDOW_BYTES),
    .IRAM_BYTES      (IRAM_BYTES)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (in_cmd),
    .address    (in_address),
    .write_data (in_write_data),
    .acc        (front_acc)
  );

  busdec_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (front_acc),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_data)
  );

  busdec_back #(
    .IRAM_BYTES (IRAM_BYTES)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_valid           (q_valid),
    .q_data            (q_data),
    .q_pop             (q_pop),
    .clearing          (clearing),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_target        (out_target),
    .out_window_index  (out_window_index),
    .out_offset        (out_offset),
    .out_read_data     (out_read_data),
    .out_forward_write (out_forward_write),
    .out_write_dropped (out_write_dropped)
  );

endmodule

// File: rtl/busdec_front.sv
// ----------------------------------------------------------------------------
// busdec_front
// Configuration registers and parallel address classification.
// ----------------------------------------------------------------------------
module busdec_front #(
  parameter int NUM_WINDOWS     = busdec_pkg::NUM_WINDOWS_DEF,
  parameter int IO_WINDOW_BYTES = busdec_pkg::IO_WINDOW_BYTES_DEF,
  parameter int IRAM_BYTES      = busdec_pkg::IRAM_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [busdec_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [busdec_pkg::CFG_DAT_W-1:0]    cfg_data,
  input  logic                                cmd,
  input  logic [busdec_pkg::ADDR_W-1:0]       address,
  input  logic [busdec_pkg::DATA_W-1:0]       write_data,
  output busdec_pkg::acc_t                    acc
);

  localparam int NW_EFF = (NUM_WINDOWS < busdec_pkg::WIN_SLOTS) ?
                          NUM_WINDOWS : busdec_pkg::WIN_SLOTS;
  localparam int AW = busdec_pkg::ADDR_W;

  logic [AW-1:0]                         io_base_r;
  logic [AW-1:0]                         ram_base_r;
  logic [busdec_pkg::IO_MASK_BITS-1:0]   rd_mask_r;
  logic [busdec_pkg::IO_MASK_BITS-1:0]   wr_mask_r;
  logic [busdec_pkg::WIN_W-1:0]          win_r [NW_EFF];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      io_base_r  <= busdec_pkg::IO_BASE_RST;
      ram_base_r <= '0;
      rd_mask_r  <= '0;
      wr_mask_r  <= '0;
      for (int i = 0; i < NW_EFF; i++) begin
        win_r[i] <= '0;
      end
    end else if (cfg_we) begin
      if (cfg_index == busdec_pkg::CFG_IO_BASE) io_base_r <= cfg_data[AW-1:0];
      if (cfg_index == busdec_pkg::CFG_RAM_BASE) ram_base_r <= cfg_data[AW-1:0];
      if (cfg_index == busdec_pkg::CFG_RD_MASK) rd_mask_r <= cfg_data;
      if (cfg_index == busdec_pkg::CFG_WR_MASK) wr_mask_r <= cfg_data;
      for (int i = 0; i < NW_EFF; i++) begin
        if (cfg_index == busdec_pkg::CFG_WIN0 + busdec_pkg::CFG_IDX_W'(i)) begin
          win_r[i] <= cfg_data[busdec_pkg::WIN_W-1:0];
        end
      end
    end
  end

  // Region distances in 17 bits: top bit set means the address is below base.
  logic [AW:0] io_diff;
  logic [AW:0] ram_diff;
  logic [AW:0] win_diff [NW_EFF];
  logic        win_hit  [NW_EFF];
  logic        io_take;
  logic        ram_hit;
  logic [busdec_pkg::IO_MASK_BITS-1:0] io_mask;

  assign io_diff  = {1'b0, address} - {1'b0, io_base_r};
  assign ram_diff = {1'b0, address} - {1'b0, ram_base_r};
  assign io_mask  = cmd ? wr_mask_r : rd_mask_r;

  // Register window counts only where the offset has a handler.
  assign io_take = !io_diff[AW] && (io_diff[AW-1:0] < AW'(IO_WINDOW_BYTES)) &&
                   (io_diff[AW-1:0] < AW'(busdec_pkg::IO_MASK_BITS)) &&
                   io_mask[io_diff[5:0]];
  assign ram_hit = !ram_diff[AW] && (ram_diff[AW-1:0] < AW'(IRAM_BYTES));

  always_comb begin
    for (int i = 0; i < NW_EFF; i++) begin
      win_diff[i] = {1'b0, address} - {1'b0, win_r[i][AW-1:0]};
      win_hit[i]  = !win_diff[i][AW] && (win_diff[i][AW-1:0] < win_r[i][2*AW-1:AW]);
    end
  end

  // Lowest priority first, so later hits override earlier ones.
  always_comb begin
    acc.target  = busdec_pkg::TGT_NONE;
    acc.win_idx = '0;
    acc.offset  = '0;
    acc.wr      = cmd;
    acc.wdata   = write_data;
    acc.fwd     = 1'b0;
    acc.drop    = 1'b0;
    for (int i = NW_EFF - 1; i >= 0; i--) begin
      if (win_hit[i]) begin
        acc.target  = busdec_pkg::TGT_EXT;
        acc.win_idx = 2'(i);
        acc.offset  = win_diff[i][AW-1:0];
        acc.fwd     = cmd && win_r[i][2*AW];
        acc.drop    = cmd && !win_r[i][2*AW];
      end
    end
    if (ram_hit) begin
      acc.target  = busdec_pkg::TGT_RAM;
      acc.win_idx = '0;
      acc.offset  = ram_diff[AW-1:0];
      acc.fwd     = 1'b0;
      acc.drop    = 1'b0;
    end
    if (io_take) begin
      acc.target  = busdec_pkg::TGT_IO;
      acc.win_idx = '0;
      acc.offset  = io_diff[AW-1:0];
      acc.fwd     = cmd;
      acc.drop    = 1'b0;
    end
  end

endmodule

// File: rtl/busdec_fifo.sv
// ----------------------------------------------------------------------------
// busdec_fifo
// Two-entry queue of classified accesses between front and back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module busdec_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  busdec_pkg::acc_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output busdec_pkg::acc_t pop_data
);

  localparam int DEPTH = busdec_pkg::FIFO_DEPTH;
  localparam int PW    = $clog2(DEPTH);

  busdec_pkg::acc_t slot_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [PW:0]      cnt_r;

  assign full      = (cnt_r == (PW+1)'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_data  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  `ASSERT_IMPL(a_no_overflow, clk, rst_n, full, !push)
  `ASSERT_IMPL(a_no_underflow, clk, rst_n, !not_empty, !pop)

endmodule

// File: rtl/busdec_back.sv
// ----------------------------------------------------------------------------
// busdec_back
// Internal RAM access, clearing pass after reset and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module busdec_back #(
  parameter int IRAM_BYTES = busdec_pkg::IRAM_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            q_valid,
  input  busdec_pkg::acc_t                q_data,
  output logic                            q_pop,
  output logic                            clearing,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_target,
  output logic [1:0]                      out_window_index,
  output logic [busdec_pkg::ADDR_W-1:0]   out_offset,
  output logic [busdec_pkg::DATA_W-1:0]   out_read_data,
  output logic                            out_forward_write,
  output logic                            out_write_dropped
);

  localparam int RAW = $clog2(IRAM_BYTES);

  logic [busdec_pkg::DATA_W-1:0] mem [IRAM_BYTES];
  logic [busdec_pkg::DATA_W-1:0] mem_q_r;
  logic [RAW-1:0]                clr_cnt_r;
  logic                          clearing_r;
  logic                          out_valid_r;
  busdec_pkg::acc_t              res_r;
  logic                          ram_rd_r;
  logic [busdec_pkg::DATA_W-1:0] rd_const_r;
  logic [RAW-1:0]                ram_idx;
  logic                          ram_wr;

  assign q_pop   = q_valid && !clearing_r && (!out_valid_r || out_ready);
  assign ram_idx = q_data.offset[RAW-1:0];
  assign ram_wr  = q_pop && (q_data.target == busdec_pkg::TGT_RAM) && q_data.wr;

  // Sweep the RAM to zero, one byte a cycle, right after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clearing_r) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
      if (clr_cnt_r == RAW'(IRAM_BYTES - 1)) begin
        clearing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_cnt_r] <= '0;
    end else if (ram_wr) begin
      mem[ram_idx] <= q_data.wdata;
    end
    if (q_pop) begin
      mem_q_r <= mem[ram_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r      <= q_data;
      ram_rd_r   <= (q_data.target == busdec_pkg::TGT_RAM) && !q_data.wr;
      rd_const_r <= ((q_data.target == busdec_pkg::TGT_NONE) && !q_data.wr) ?
                    busdec_pkg::UNMAPPED_READ : '0;
    end
  end

  assign clearing          = clearing_r;
  assign out_valid         = out_valid_r;
  assign out_target        = res_r.target;
  assign out_window_index  = res_r.win_idx;
  assign out_offset        = res_r.offset;
  assign out_read_data     = ram_rd_r ? mem_q_r : rd_const_r;
  assign out_forward_write = res_r.fwd;
  assign out_write_dropped = res_r.drop;

  `ASSERT_IMPL(a_no_pop_while_clearing, clk, rst_n, clearing_r, !q_pop)
  `ASSERT_NEXT(a_clear_once, clk, rst_n, !clearing_r, !clearing_r)
  `ASSERT_IMPL(a_drop_only_ext, clk, rst_n, out_valid_r && res_r.drop,
               (res_r.target == busdec_pkg::TGT_EXT) && !res_r.fwd && res_r.wr)

endmodule

// File: test/tb_bus_address_decoder_with_iram.sv
// ----------------------------------------------------------------------------
// tb_bus_address_decoder_with_iram
// Self-checking bench for the byte bus address decoder with internal RAM.
// ----------------------------------------------------------------------------
// A queue of bus accesses feeds a valid/ready driver. A decode predictor
// keeps its own copy of the memory map and of the RAM contents. It turns
// every accepted access word into one expected result word. The monitor
// compares each result word field by field with the oldest expected word.
// Directed accesses cover the priority order and the region edges. Random
// phases then reprogram the map and run under different idle and stall
// patterns, one of them with a long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_bus_address_decoder_with_iram;
  timeunit 1ns;
  timeprecision 1ps;

  import busdec_pkg::*;

  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // map programming styles of the random phases
  localparam int MAP_RANDOM       = 0;
  localparam int MAP_ALL_HANDLERS = 1;
  localparam int MAP_NO_HANDLERS  = 2;

  localparam int RANDOM_PHASES   = 8;
  localparam int WORDS_PER_PHASE = 88;
  localparam int HOLD_CYCLES     = 300;
  localparam int MAX_REPORTS     = 10;
  localparam int DRAIN_CYCLES    = 20;

  typedef struct packed {
    logic              cmd;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] wdata;
  } bus_access_t;

  typedef struct packed {
    target_t           target;
    logic [1:0]        window_index;
    logic [ADDR_W-1:0] offset;
    logic [DATA_W-1:0] read_data;
    logic              forward_write;
    logic              write_dropped;
  } decode_result_t;

  // --------------------------------------------------------------------------
  // clock and DUT signals; every input starts at a known value
  // --------------------------------------------------------------------------
  logic                 clk           = 1'b0;
  logic                 rst_n         = 1'b0;
  logic                 cfg_valid     = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index     = '0;
  logic [CFG_DAT_W-1:0] cfg_data      = '0;
  logic                 in_valid      = 1'b0;
  logic                 in_ready;
  logic                 in_cmd        = 1'b0;
  logic [ADDR_W-1:0]    in_address    = '0;
  logic [DATA_W-1:0]    in_write_data = '0;
  logic                 out_valid;
  logic                 out_ready     = 1'b0;
  logic [1:0]           out_target;
  logic [1:0]           out_window_index;
  logic [ADDR_W-1:0]    out_offset;
  logic [DATA_W-1:0]    out_read_data;
  logic                 out_forward_write;
  logic                 out_write_dropped;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  bus_address_decoder_with_iram u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_address        (in_address),
    .in_write_data     (in_write_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_target        (out_target),
    .out_window_index  (out_window_index),
    .out_offset        (out_offset),
    .out_read_data     (out_read_data),
    .out_forward_write (out_forward_write),
    .out_write_dropped (out_write_dropped)
  );

  // --------------------------------------------------------------------------
  // bench state
  // --------------------------------------------------------------------------
  bus_access_t    access_queue[$];     // words waiting for the driver
  decode_result_t pending_results[$];  // predicted words, oldest first
  int unsigned    mismatch_count = 0;

  // idle controls; the percentages and hold_req change only on the falling edge
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  logic        hold_req      = 1'b0;   // toggle to start one long hold-off
  logic        hold_ack      = 1'b0;
  int unsigned hold_left     = 0;

  // predictor copy of the memory map and the RAM
  logic [ADDR_W-1:0]       map_io_base;
  logic [ADDR_W-1:0]       map_ram_base;
  logic [IO_MASK_BITS-1:0] map_rd_mask;
  logic [IO_MASK_BITS-1:0] map_wr_mask;
  logic [WIN_W-1:0]        map_window [WIN_SLOTS];
  logic [DATA_W-1:0]       iram_image [IRAM_BYTES_DEF];

  // --------------------------------------------------------------------------
  // decode predictor
  // --------------------------------------------------------------------------
  // Work the region end out in 32 bits so a region never wraps past 0xFFFF.
  function automatic bit in_span(int unsigned adr, int unsigned base, int unsigned size);
    return adr >= base && adr < base + size;
  endfunction

  // Decode one access in priority order and apply RAM writes to the image.
  function automatic decode_result_t decode_access(bus_access_t acc);
    decode_result_t          res;
    int unsigned             adr;
    int unsigned             off;
    logic [IO_MASK_BITS-1:0] mask;
    logic [ADDR_W-1:0]       win_start;
    logic [ADDR_W-1:0]       win_len;
    logic                    is_write;
    is_write          = (acc.cmd == CMD_WRITE);
    adr               = acc.address;
    res.target        = TGT_NONE;
    res.window_index  = '0;
    res.offset        = '0;
    res.read_data     = is_write ? '0 : UNMAPPED_READ;
    res.forward_write = 1'b0;
    res.write_dropped = 1'b0;
    mask              = is_write ? map_wr_mask : map_rd_mask;

    // register window, only where a handler exists for this direction
    if (in_span(adr, map_io_base, IO_WINDOW_BYTES_DEF)) begin
      off = adr - map_io_base;
      if (off < IO_MASK_BITS && mask[off[5:0]]) begin
        res.target        = TGT_IO;
        res.offset        = ADDR_W'(off);
        res.read_data     = '0;
        res.forward_write = is_write;
        return res;
      end
    end

    // internal RAM is served locally
    if (in_span(adr, map_ram_base, IRAM_BYTES_DEF)) begin
      off        = adr - map_ram_base;
      res.target = TGT_RAM;
      res.offset = ADDR_W'(off);
      if (is_write) begin
        iram_image[off[7:0]] = acc.wdata;
      end else begin
        res.read_data = iram_image[off[7:0]];
      end
      return res;
    end

    // external windows: lowest index wins, zero length never matches
    for (int k = 0; k < NUM_WINDOWS_DEF; k++) begin
      win_start = map_window[k][15:0];
      win_len   = map_window[k][31:16];
      if (in_span(adr, win_start, win_len)) begin
        res.target       = TGT_EXT;
        res.window_index = 2'(k);
        res.offset       = ADDR_W'(adr - win_start);
        res.read_data    = '0;
        if (is_write) begin
          res.forward_write = map_window[k][32];
          res.write_dropped = !map_window[k][32];
        end
        return res;
      end
    end
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // access driver: advance on accept, hold the word until taken
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    bus_access_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (access_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt            = access_queue.pop_front();
        in_valid      <= 1'b1;
        in_cmd        <= nxt.cmd;
        in_address    <= nxt.address;
        in_write_data <= nxt.wdata;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // result ready: random stalls, plus a long hold-off counted here
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (hold_ack != hold_req) begin
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // --------------------------------------------------------------------------
  // monitor: predict on accept, then check the result word of this edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    bus_access_t    acc;
    decode_result_t got;
    decode_result_t want;
    if (rst_n && in_valid && in_ready) begin
      acc.cmd     = in_cmd;
      acc.address = in_address;
      acc.wdata   = in_write_data;
      pending_results.push_back(decode_access(acc));
    end
    if (rst_n && out_valid && out_ready) begin
      got.target        = target_t'(out_target);
      got.window_index  = out_window_index;
      got.offset        = out_offset;
      got.read_data     = out_read_data;
      got.forward_write = out_forward_write;
      got.write_dropped = out_write_dropped;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected result word tgt=%0d win=%0d off=%h rd=%h fwd=%b drop=%b",
                   $realtime, got.target, got.window_index, got.offset, got.read_data,
                   got.forward_write, got.write_dropped);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: mismatch expected tgt=%0d win=%0d off=%h rd=%h fwd=%b drop=%b",
                     $realtime, want.target, want.window_index, want.offset,
                     want.read_data, want.forward_write, want.write_dropped);
            $display("%0t:          got      tgt=%0d win=%0d off=%h rd=%h fwd=%b drop=%b",
                     $realtime, got.target, got.window_index, got.offset, got.read_data,
                     got.forward_write, got.write_dropped);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------
  task automatic queue_access(input logic cmd, input logic [ADDR_W-1:0] adr,
                              input logic [DATA_W-1:0] wdata);
    bus_access_t acc;
    acc.cmd     = cmd;
    acc.address = adr;
    acc.wdata   = wdata;
    access_queue.push_back(acc);
  endtask

  // Write one register and mirror it into the predictor map on accept.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_IO_BASE:  map_io_base  = data[ADDR_W-1:0];
      CFG_RAM_BASE: map_ram_base = data[ADDR_W-1:0];
      CFG_RD_MASK:  map_rd_mask  = data[IO_MASK_BITS-1:0];
      CFG_WR_MASK:  map_wr_mask  = data[IO_MASK_BITS-1:0];
      default:      map_window[2'(idx - CFG_WIN0)] = data[WIN_W-1:0];
    endcase
  endtask

  task automatic set_map(input logic [ADDR_W-1:0] iob, input logic [ADDR_W-1:0] rb,
                         input logic [IO_MASK_BITS-1:0] rdm,
                         input logic [IO_MASK_BITS-1:0] wrm,
                         input logic [WIN_W-1:0] w0, input logic [WIN_W-1:0] w1,
                         input logic [WIN_W-1:0] w2, input logic [WIN_W-1:0] w3);
    write_reg(CFG_IO_BASE, CFG_DAT_W'(iob));
    write_reg(CFG_RAM_BASE, CFG_DAT_W'(rb));
    write_reg(CFG_RD_MASK, CFG_DAT_W'(rdm));
    write_reg(CFG_WR_MASK, CFG_DAT_W'(wrm));
    write_reg(CFG_WIN0, CFG_DAT_W'(w0));
    write_reg(CFG_WIN0 + 3'd1, CFG_DAT_W'(w1));
    write_reg(CFG_WIN0 + 3'd2, CFG_DAT_W'(w2));
    write_reg(CFG_WIN0 + 3'd3, CFG_DAT_W'(w3));
  endtask

  // Draw a window: disabled, full length, random or short; sometimes overlap
  // the one before it.
  function automatic logic [WIN_W-1:0] random_window(logic [ADDR_W-1:0] prev_start);
    logic [ADDR_W-1:0] win_start;
    logic [ADDR_W-1:0] win_len;
    win_start = ADDR_W'($urandom);
    if ($urandom_range(2) == 0) win_start = prev_start + ADDR_W'($urandom_range(200));
    case ($urandom_range(5))
      0:       win_len = '0;
      1:       win_len = '1;
      2:       win_len = ADDR_W'($urandom);
      default: win_len = ADDR_W'($urandom_range(1, 300));
    endcase
    return {1'($urandom), win_len, win_start};
  endfunction

  task automatic program_map(input int style);
    logic [ADDR_W-1:0]       iob;
    logic [ADDR_W-1:0]       rb;
    logic [IO_MASK_BITS-1:0] rdm;
    logic [IO_MASK_BITS-1:0] wrm;
    logic [WIN_W-1:0]        w [WIN_SLOTS];
    iob = ADDR_W'($urandom);
    rb  = ADDR_W'($urandom);
    case ($urandom_range(3))
      0:       rb  = iob + ADDR_W'($urandom_range(IO_WINDOW_BYTES_DEF - 1));
      1:       iob = 16'hFFFF - ADDR_W'($urandom_range(IO_WINDOW_BYTES_DEF));
      2:       rb  = 16'hFFFF - ADDR_W'($urandom_range(IRAM_BYTES_DEF + 40));
      default: ;
    endcase
    rdm = {$urandom, $urandom};
    wrm = {$urandom, $urandom};
    if (style == MAP_ALL_HANDLERS) begin
      rdm = '1;
      wrm = '1;
    end else if (style == MAP_NO_HANDLERS) begin
      rdm = '0;
      wrm = '0;
    end
    w[0] = random_window(rb);
    for (int k = 1; k < WIN_SLOTS; k++) w[k] = random_window(w[k-1][15:0]);
    set_map(iob, rb, rdm, wrm, w[0], w[1], w[2], w[3]);
  endtask

  // Aim most addresses at or just past the programmed regions.
  function automatic logic [ADDR_W-1:0] pick_address();
    logic [1:0] k;
    k = 2'($urandom_range(WIN_SLOTS - 1));
    case ($urandom_range(9))
      0, 1:    return map_io_base + ADDR_W'($urandom_range(IO_WINDOW_BYTES_DEF + 3));
      2, 3:    return map_ram_base + ADDR_W'($urandom_range(IRAM_BYTES_DEF + 3));
      4, 5, 6: return map_window[k][15:0] + ADDR_W'($urandom_range(map_window[k][31:16] + 3));
      7: begin
        case ($urandom_range(3))
          0:       return '0;
          1:       return '1;
          2:       return map_io_base - 16'd1;
          default: return map_ram_base - 16'd1;
        endcase
      end
      default: return ADDR_W'($urandom);
    endcase
  endfunction

  // Wait until the driver is empty and every predicted word has come back.
  task automatic wait_drained();
    do @(negedge clk); while (access_queue.size() != 0 || in_valid ||
                              pending_results.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    // mirror the reset map: register window at 0x1000, all else cleared
    map_io_base  = IO_BASE_RST;
    map_ram_base = '0;
    map_rd_mask  = '0;
    map_wr_mask  = '0;
    foreach (map_window[k]) map_window[k] = '0;
    foreach (iram_image[a]) iram_image[a] = '0;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words on the reset map. The DUT is still sweeping its RAM, so
    // the first word waits on in_ready.
    @(negedge clk);
    queue_access(CMD_READ,  16'h0000, 8'h00);  // cleared RAM byte
    queue_access(CMD_WRITE, 16'h00FF, 8'hFF);  // last RAM byte
    queue_access(CMD_READ,  16'h00FF, 8'h00);
    queue_access(CMD_READ,  16'h1000, 8'h00);  // register without handler, unmapped
    wait_drained();

    // Register window on top of the RAM base; windows 0 and 1 overlap,
    // window 2 runs past 0xFFFF, window 3 is disabled.
    set_map(16'h0100, 16'h0100,
            64'h8000_0000_0000_0001, 64'h8000_0000_0000_0002,
            {1'b0, 16'h0100, 16'h2000}, {1'b1, 16'h0100, 16'h2080},
            {1'b1, 16'h0020, 16'hFFF0}, {1'b0, 16'h0000, 16'h0300});
    @(negedge clk);
    queue_access(CMD_READ,  16'h0100, 8'h00);  // read handler at offset 0
    queue_access(CMD_WRITE, 16'h0100, 8'h5A);  // no write handler: falls to RAM
    queue_access(CMD_WRITE, 16'h0101, 8'h00);  // write handler at offset 1
    queue_access(CMD_READ,  16'h0101, 8'h00);  // no read handler: RAM
    queue_access(CMD_READ,  16'h013F, 8'h00);  // top register offset
    queue_access(CMD_WRITE, 16'h013F, 8'hFF);
    queue_access(CMD_WRITE, 16'h0102, 8'h3C);
    queue_access(CMD_READ,  16'h0102, 8'h00);  // read back through RAM
    queue_access(CMD_READ,  16'h0140, 8'h00);  // past the register window
    queue_access(CMD_READ,  16'h2000, 8'h00);  // read-only window read
    queue_access(CMD_WRITE, 16'h2000, 8'h11);  // dropped write
    queue_access(CMD_WRITE, 16'h20A0, 8'h22);  // overlap: window 0 wins
    queue_access(CMD_WRITE, 16'h2150, 8'hA5);  // writable window 1
    queue_access(CMD_READ,  16'hFFFF, 8'h00);  // top of window 2
    queue_access(CMD_READ,  16'h0005, 8'h00);  // window 2 does not wrap
    queue_access(CMD_WRITE, 16'h00FF, 8'h77);  // unmapped write
    queue_access(CMD_READ,  16'h0300, 8'h00);  // disabled window
    wait_drained();

    // Extremes: register window and RAM pinned at the top of the address space.
    set_map(16'hFFFF, 16'hFF80, '1, '1,
            {1'b1, 16'hFFFF, 16'hFFFF}, '0, '0, {1'b0, 16'hFFFF, 16'h0000});
    @(negedge clk);
    queue_access(CMD_READ,  16'hFFFF, 8'h00);
    queue_access(CMD_WRITE, 16'hFFFF, 8'hFF);
    queue_access(CMD_WRITE, 16'hFFC0, 8'h00);
    queue_access(CMD_READ,  16'hFF80, 8'h00);
    queue_access(CMD_WRITE, 16'h0000, 8'h99);  // full-length read-only window
    wait_drained();

    // Random phases: reprogram the map, then rotate through the idle patterns.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      program_map(p == 0 ? MAP_ALL_HANDLERS : p == 1 ? MAP_NO_HANDLERS : MAP_RANDOM);
      @(negedge clk);
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 87;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 87;
        end
        default: begin
          send_idle_pct = 11;
          stall_pct     = 11;
        end
      endcase
      for (int n = 0; n < WORDS_PER_PHASE; n++)
        queue_access(1'($urandom_range(1)), pick_address(), DATA_W'($urandom));
      // hold the result side off while the driver keeps offering words
      if (p == 4) hold_req = ~hold_req;
      wait_drained();
    end

    // let any stray result word show up before judging
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pending_results.size() != 0) begin
      mismatch_count++;
      $display("%0d result words never arrived", pending_results.size());
    end
    if (mismatch_count == 0) begin
      $display("PASS bus_address_decoder_with_iram");
    end else begin
      $display("FAIL bus_address_decoder_with_iram");
    end
    $finish;
  end

  // watchdog
  initial begin
    #400000;
    $display("FAIL bus_address_decoder_with_iram");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/busdec_pkg.sv
rtl/busdec_front.sv
rtl/busdec_fifo.sv
rtl/busdec_back.sv
rtl/bus_address_decoder_with_iram.sv
test/tb_bus_address_decoder_with_iram.sv
